/* design/selt_pkg.sv */
// ----------------------------------------------------------------------------
// selt_pkg
// Shared codes, defaults and control/status types of the lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package selt_pkg;

  // default table sizes
  localparam int KEY_ENTRIES_DEF  = 32;
  localparam int HELD_ENTRIES_DEF = 64;
  localparam int WAIT_ENTRIES_DEF = 32;

  // request actions
  localparam logic [1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;
  localparam logic [1:0] ACT_QUERY   = 2'd3;

  // lock modes
  localparam logic MODE_SHARED = 1'b0;
  localparam logic MODE_EXCL   = 1'b1;

  // result status codes
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_ALREADY  = 3'd1;
  localparam logic [2:0] ST_WAIT     = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_UPG_REF  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  // datapath operations
  localparam logic [3:0] OP_IDLE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_CLR  = 4'd2;
  localparam logic [3:0] OP_HRD  = 4'd3;
  localparam logic [3:0] OP_HEV  = 4'd4;
  localparam logic [3:0] OP_KRD  = 4'd5;
  localparam logic [3:0] OP_KEV  = 4'd6;
  localparam logic [3:0] OP_WRD  = 4'd7;
  localparam logic [3:0] OP_WEV  = 4'd8;
  localparam logic [3:0] OP_ACQ  = 4'd9;
  localparam logic [3:0] OP_DONE = 4'd10;

  typedef struct packed {
    logic [3:0] op;
  } selt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic h_last;
    logic k_last;
    logic w_last;
    logic hit;
  } selt_stat_t;

endpackage

`default_nettype wire

/* design/shared_exclusive_lock_table.sv */
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table
// Shared/exclusive lock table for transactions with waiters and timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken at a clock edge with start high and busy low.
//   in_action selects acquire, release-all, tick or query; in_xid,
//   in_target_key and in_mode ride along.
//   Each word yields one result word, shown for exactly one cycle with
//   out_strobe high. The receiver cannot stall; it must take it then.
//   cfg_data (wait limit in ticks, 0 = never time out) is written whenever
//   cfg_valid is high; cfg_ready is always high. Write it only while idle.
// Scans (H, K, W = held, key, waiting table depths):
//   Every table is a single-port memory scanned one entry at a time
//   (address, then registered read and compare), so the scans set the rate.
//   acquire : held, key and waiting scans, then the acquire step and result
//   query   : held and key scans; tick: waiting scan
//   release : held scan plus up to K key entries per freed lock (key lookup)
//   busy drops in the cycle the strobe shows, so the next word can go in.
// Reset: synchronous rst_n; then a clearing pass over max(H,K,W) entries
//   invalidates all tables while busy stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_exclusive_lock_table #(
  parameter int KEY_ENTRIES  = selt_pkg::KEY_ENTRIES_DEF,
  parameter int HELD_ENTRIES = selt_pkg::HELD_ENTRIES_DEF,
  parameter int WAIT_ENTRIES = selt_pkg::WAIT_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_xid,
  input  logic [31:0] in_target_key,
  input  logic        in_mode,
  // result channel
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic        out_holds_lock,
  output logic        out_mode_is_held,
  output logic [6:0]  out_released_count,
  output logic [6:0]  out_held_total,
  output logic [5:0]  out_waiting_total,
  // wait limit register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import selt_pkg::*;

  selt_cmd_t  cmd;   // controller -> datapath, one op per cycle
  selt_stat_t stat;  // scan end flags and hit from datapath

  // register write never waits
  assign cfg_ready = 1'b1;

  selt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  selt_dp #(
    .KEY_ENTRIES  (KEY_ENTRIES),
    .HELD_ENTRIES (HELD_ENTRIES),
    .WAIT_ENTRIES (WAIT_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_xid             (in_xid),
    .in_target_key      (in_target_key),
    .in_mode            (in_mode),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_holds_lock     (out_holds_lock),
    .out_mode_is_held   (out_mode_is_held),
    .out_released_count (out_released_count),
    .out_held_total     (out_held_total),
    .out_waiting_total  (out_waiting_total)
  );

endmodule

`default_nettype wire

/* design/selt_ctrl.sv */
// ----------------------------------------------------------------------------
// selt_ctrl
// Sequencer: clearing pass, table scans and result slot per request.
// ----------------------------------------------------------------------------
`default_nettype none

module selt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_action,
  input  selt_pkg::selt_stat_t stat,
  output selt_pkg::selt_cmd_t  cmd,
  output logic                 busy
);
  import selt_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HRD  = 4'd2;
  localparam logic [3:0] S_HEV  = 4'd3;
  localparam logic [3:0] S_KRD  = 4'd4;
  localparam logic [3:0] S_KEV  = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_WEV  = 4'd7;
  localparam logic [3:0] S_ACQ  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [1:0] act_r, act_nxt;

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    cmd.op    = OP_IDLE;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          act_nxt   = in_action;
          state_nxt = (in_action == ACT_TICK) ? S_WRD : S_HRD;
        end
      end
      S_HRD: begin
        cmd.op    = OP_HRD;
        state_nxt = S_HEV;
      end
      S_HEV: begin
        cmd.op = OP_HEV;
        if (act_r == ACT_RELEASE && stat.hit) state_nxt = S_KRD;
        else if (stat.h_last) state_nxt = (act_r == ACT_RELEASE) ? S_DONE : S_KRD;
        else state_nxt = S_HRD;
      end
      S_KRD: begin
        cmd.op    = OP_KRD;
        state_nxt = S_KEV;
      end
      S_KEV: begin
        cmd.op = OP_KEV;
        if (act_r == ACT_RELEASE) begin
          if (stat.hit || stat.k_last) state_nxt = stat.h_last ? S_DONE : S_HRD;
          else state_nxt = S_KRD;
        end else if (stat.k_last) begin
          state_nxt = (act_r == ACT_ACQUIRE) ? S_WRD : S_DONE;
        end else begin
          state_nxt = S_KRD;
        end
      end
      S_WRD: begin
        cmd.op    = OP_WRD;
        state_nxt = S_WEV;
      end
      S_WEV: begin
        cmd.op = OP_WEV;
        if (stat.w_last) state_nxt = (act_r == ACT_ACQUIRE) ? S_ACQ : S_DONE;
        else state_nxt = S_WRD;
      end
      S_ACQ: begin
        cmd.op    = OP_ACQ;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op    = OP_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      act_r   <= ACT_ACQUIRE;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* design/selt_dp.sv */
// ----------------------------------------------------------------------------
// selt_dp
// Key, held and waiting tables in memories, scan trackers, counters, result.
// ----------------------------------------------------------------------------
`default_nettype none

module selt_dp #(
  parameter int KEY_ENTRIES  = selt_pkg::KEY_ENTRIES_DEF,
  parameter int HELD_ENTRIES = selt_pkg::HELD_ENTRIES_DEF,
  parameter int WAIT_ENTRIES = selt_pkg::WAIT_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  selt_pkg::selt_cmd_t  cmd,
  output selt_pkg::selt_stat_t stat,
  input  logic [1:0]           in_action,
  input  logic [15:0]          in_xid,
  input  logic [31:0]          in_target_key,
  input  logic                 in_mode,
  input  logic                 cfg_valid,
  input  logic [15:0]          cfg_data,
  output logic                 out_strobe,
  output logic [2:0]           out_status,
  output logic                 out_holds_lock,
  output logic                 out_mode_is_held,
  output logic [6:0]           out_released_count,
  output logic [6:0]           out_held_total,
  output logic [5:0]           out_waiting_total
);
  import selt_pkg::*;

  localparam int KIW  = $clog2(KEY_ENTRIES);
  localparam int HIW  = $clog2(HELD_ENTRIES);
  localparam int WIW  = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
  localparam int MAXN = (KEY_ENTRIES > HELD_ENTRIES) ?
                        ((KEY_ENTRIES > WAIT_ENTRIES) ? KEY_ENTRIES : WAIT_ENTRIES) :
                        ((HELD_ENTRIES > WAIT_ENTRIES) ? HELD_ENTRIES : WAIT_ENTRIES);
  localparam int CIW  = $clog2(MAXN);
  localparam int HCW  = $clog2(HELD_ENTRIES + 1);
  localparam int WCW  = $clog2(WAIT_ENTRIES + 1);

  typedef struct packed {
    logic            valid;
    logic [31:0]     key;
    logic [HCW-1:0]  sc;
    logic            excl;
    logic [15:0]     exid;
  } key_ent_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] xid;
    logic [31:0] key;
    logic        mode;
  } held_ent_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] xid;
    logic [31:0] key;
    logic        mode;
    logic [15:0] age;
  } wait_ent_t;

  // table memories
  key_ent_t  key_mem  [KEY_ENTRIES];
  held_ent_t held_mem [HELD_ENTRIES];
  wait_ent_t wait_mem [WAIT_ENTRIES];

  key_ent_t  key_rd_r,  key_wd;
  held_ent_t held_rd_r, held_wd;
  wait_ent_t wait_rd_r, wait_wd;
  logic            key_we, held_we, wait_we;
  logic [KIW-1:0]  key_wa;
  logic [HIW-1:0]  held_wa;
  logic [WIW-1:0]  wait_wa;

  // control registers
  logic [15:0]    limit_r;
  logic [HCW-1:0] held_cnt_r, held_cnt_nxt;
  logic [WCW-1:0] wait_cnt_r, wait_cnt_nxt;
  logic           strobe_r, strobe_nxt;
  logic [CIW-1:0] cidx_r, cidx_nxt;
  logic [HIW-1:0] hidx_r, hidx_nxt;
  logic [KIW-1:0] kidx_r, kidx_nxt;
  logic [WIW-1:0] widx_r, widx_nxt;
  logic h_found_r, h_found_nxt, h_free_ok_r, h_free_ok_nxt;
  logic k_found_r, k_found_nxt, k_free_ok_r, k_free_ok_nxt;
  logic w_found_r, w_found_nxt, w_free_ok_r, w_free_ok_nxt;

  // payload registers
  logic [1:0]     act_r, act_nxt;
  logic [15:0]    xid_r, xid_nxt;
  logic [31:0]    key_r, key_nxt;
  logic           mode_r, mode_nxt;
  logic           h_mode_r, h_mode_nxt;
  logic [HIW-1:0] h_free_r, h_free_nxt;
  logic [KIW-1:0] k_idx_r, k_idx_nxt, k_free_r, k_free_nxt;
  logic [HCW-1:0] k_sc_r, k_sc_nxt;
  logic           k_excl_r, k_excl_nxt;
  logic [15:0]    k_exid_r, k_exid_nxt;
  logic [WIW-1:0] w_idx_r, w_idx_nxt, w_free_r, w_free_nxt;
  logic [15:0]    w_age_r, w_age_nxt;
  logic [31:0]    rl_key_r, rl_key_nxt;
  logic           rl_mode_r, rl_mode_nxt;
  logic [HCW-1:0] rel_cnt_r, rel_cnt_nxt;
  logic [2:0]     res_r, res_nxt;
  logic [2:0]     o_status_r, o_status_nxt;
  logic           o_holds_r, o_holds_nxt, o_mheld_r, o_mheld_nxt;
  logic [6:0]     o_rel_r, o_rel_nxt, o_held_r, o_held_nxt;
  logic [5:0]     o_wait_r, o_wait_nxt;

  logic           h_hit, h_hit_rel, k_hit, w_hit, grant, rl_excl;
  logic [31:0]    k_cmp;
  logic [HCW-1:0] rl_sc;

  assign k_cmp     = (act_r == ACT_RELEASE) ? rl_key_r : key_r;
  assign h_hit_rel = held_rd_r.valid && (held_rd_r.xid == xid_r);
  assign h_hit     = h_hit_rel && (held_rd_r.key == key_r);
  assign k_hit     = key_rd_r.valid && (key_rd_r.key == k_cmp);
  assign w_hit     = wait_rd_r.valid && (wait_rd_r.xid == xid_r) && (wait_rd_r.key == key_r);
  assign grant     = !k_found_r || ((mode_r == MODE_SHARED) ? !k_excl_r
                                    : (!k_excl_r && (k_sc_r == '0)));

  // key entry after one of its holders leaves
  assign rl_sc   = (rl_mode_r == MODE_SHARED && key_rd_r.sc != '0) ?
                   key_rd_r.sc - HCW'(1) : key_rd_r.sc;
  assign rl_excl = (rl_mode_r == MODE_SHARED) ? key_rd_r.excl : 1'b0;

  assign stat.clr_last = (cidx_r == CIW'(MAXN - 1));
  assign stat.h_last   = (hidx_r == HIW'(HELD_ENTRIES - 1));
  assign stat.k_last   = (kidx_r == KIW'(KEY_ENTRIES - 1));
  assign stat.w_last   = (widx_r == WIW'(WAIT_ENTRIES - 1));
  assign stat.hit      = (cmd.op == OP_HEV) ? h_hit_rel : k_hit;

  always_comb begin
    held_cnt_nxt = held_cnt_r;  wait_cnt_nxt = wait_cnt_r;
    strobe_nxt   = 1'b0;        cidx_nxt     = cidx_r;
    hidx_nxt     = hidx_r;      kidx_nxt     = kidx_r;     widx_nxt = widx_r;
    h_found_nxt  = h_found_r;   h_free_ok_nxt = h_free_ok_r;
    k_found_nxt  = k_found_r;   k_free_ok_nxt = k_free_ok_r;
    w_found_nxt  = w_found_r;   w_free_ok_nxt = w_free_ok_r;
    act_nxt      = act_r;       xid_nxt   = xid_r;   key_nxt = key_r;  mode_nxt = mode_r;
    h_mode_nxt   = h_mode_r;    h_free_nxt = h_free_r;
    k_idx_nxt    = k_idx_r;     k_free_nxt = k_free_r;  k_sc_nxt = k_sc_r;
    k_excl_nxt   = k_excl_r;    k_exid_nxt = k_exid_r;
    w_idx_nxt    = w_idx_r;     w_free_nxt = w_free_r;  w_age_nxt = w_age_r;
    rl_key_nxt   = rl_key_r;    rl_mode_nxt = rl_mode_r;
    rel_cnt_nxt  = rel_cnt_r;   res_nxt = res_r;
    o_status_nxt = o_status_r;  o_holds_nxt = o_holds_r;  o_mheld_nxt = o_mheld_r;
    o_rel_nxt    = o_rel_r;     o_held_nxt = o_held_r;    o_wait_nxt = o_wait_r;
    key_we  = 1'b0;  key_wa  = kidx_r;  key_wd  = key_rd_r;
    held_we = 1'b0;  held_wa = hidx_r;  held_wd = held_rd_r;
    wait_we = 1'b0;  wait_wa = widx_r;  wait_wd = wait_rd_r;

    unique case (cmd.op)
      OP_CLR: begin
        key_wa  = KIW'(cidx_r);
        held_wa = HIW'(cidx_r);
        wait_wa = WIW'(cidx_r);
        key_wd  = '0;
        held_wd = '0;
        wait_wd = '0;
        key_we  = (32'(cidx_r) < KEY_ENTRIES);
        held_we = (32'(cidx_r) < HELD_ENTRIES);
        wait_we = (32'(cidx_r) < WAIT_ENTRIES);
        cidx_nxt = cidx_r + CIW'(1);
      end
      OP_LOAD: begin
        act_nxt  = in_action;
        xid_nxt  = in_xid;
        key_nxt  = in_target_key;
        mode_nxt = in_mode;
        hidx_nxt = '0;  kidx_nxt = '0;  widx_nxt = '0;
        h_found_nxt = 1'b0;  h_free_ok_nxt = 1'b0;
        k_found_nxt = 1'b0;  k_free_ok_nxt = 1'b0;
        w_found_nxt = 1'b0;  w_free_ok_nxt = 1'b0;
        rel_cnt_nxt = '0;
        res_nxt     = ST_DONE;
      end
      OP_HEV: begin
        if (act_r == ACT_RELEASE) begin
          // stay on a hit until its key entry is updated
          if (h_hit_rel) begin
            rl_key_nxt  = held_rd_r.key;
            rl_mode_nxt = held_rd_r.mode;
          end else begin
            hidx_nxt = hidx_r + HIW'(1);
          end
        end else begin
          if (h_hit) begin
            h_found_nxt = 1'b1;
            h_mode_nxt  = held_rd_r.mode;
          end
          if (!held_rd_r.valid && !h_free_ok_r) begin
            h_free_ok_nxt = 1'b1;
            h_free_nxt    = hidx_r;
          end
          hidx_nxt = hidx_r + HIW'(1);
        end
      end
      OP_KEV: begin
        if (act_r == ACT_RELEASE) begin
          if (k_hit || stat.k_last) begin
            if (k_hit) begin
              key_we       = 1'b1;
              key_wd.sc    = rl_sc;
              key_wd.excl  = rl_excl;
              key_wd.exid  = rl_excl ? key_rd_r.exid : 16'd0;
              key_wd.valid = rl_excl || (rl_sc != '0);
            end
            held_we       = 1'b1;
            held_wd       = '0;
            held_cnt_nxt  = held_cnt_r - HCW'(1);
            rel_cnt_nxt   = rel_cnt_r + HCW'(1);
            hidx_nxt      = hidx_r + HIW'(1);
            kidx_nxt      = '0;
          end else begin
            kidx_nxt = kidx_r + KIW'(1);
          end
        end else begin
          if (k_hit) begin
            k_found_nxt = 1'b1;
            k_idx_nxt   = kidx_r;
            k_sc_nxt    = key_rd_r.sc;
            k_excl_nxt  = key_rd_r.excl;
            k_exid_nxt  = key_rd_r.exid;
          end
          if (!key_rd_r.valid && !k_free_ok_r) begin
            k_free_ok_nxt = 1'b1;
            k_free_nxt    = kidx_r;
          end
          kidx_nxt = kidx_r + KIW'(1);
        end
      end
      OP_WEV: begin
        if (act_r == ACT_TICK) begin
          if (wait_rd_r.valid && wait_rd_r.age != 16'hFFFF) begin
            wait_we     = 1'b1;
            wait_wd.age = wait_rd_r.age + 16'd1;
          end
        end else begin
          if (w_hit) begin
            w_found_nxt = 1'b1;
            w_idx_nxt   = widx_r;
            w_age_nxt   = wait_rd_r.age;
          end
          if (!wait_rd_r.valid && !w_free_ok_r) begin
            w_free_ok_nxt = 1'b1;
            w_free_nxt    = widx_r;
          end
        end
        widx_nxt = widx_r + WIW'(1);
      end
      OP_ACQ: begin
        if (h_found_r) begin
          res_nxt = (h_mode_r == MODE_SHARED && mode_r == MODE_EXCL) ? ST_UPG_REF : ST_ALREADY;
        end else if (grant) begin
          if (!h_free_ok_r || (!k_found_r && !k_free_ok_r)) begin
            res_nxt = ST_FULL;
          end else begin
            key_we       = 1'b1;
            key_wa       = k_found_r ? k_idx_r : k_free_r;
            key_wd.valid = 1'b1;
            key_wd.key   = key_r;
            key_wd.sc    = (k_found_r ? k_sc_r : '0) + HCW'(mode_r == MODE_SHARED);
            key_wd.excl  = (mode_r == MODE_EXCL) || (k_found_r && k_excl_r);
            key_wd.exid  = (mode_r == MODE_EXCL) ? xid_r : (k_found_r ? k_exid_r : 16'd0);
            held_we       = 1'b1;
            held_wa       = h_free_r;
            held_wd.valid = 1'b1;
            held_wd.xid   = xid_r;
            held_wd.key   = key_r;
            held_wd.mode  = mode_r;
            held_cnt_nxt  = held_cnt_r + HCW'(1);
            if (w_found_r) begin
              wait_we      = 1'b1;
              wait_wa      = w_idx_r;
              wait_wd      = '0;
              wait_cnt_nxt = wait_cnt_r - WCW'(1);
            end
            res_nxt = ST_GRANTED;
          end
        end else if (w_found_r) begin
          wait_we       = 1'b1;
          wait_wa       = w_idx_r;
          wait_wd.xid   = xid_r;
          wait_wd.key   = key_r;
          wait_wd.mode  = mode_r;
          wait_wd.age   = w_age_r;
          if (limit_r != 16'd0 && w_age_r >= limit_r) begin
            wait_wd.valid = 1'b0;
            wait_cnt_nxt  = wait_cnt_r - WCW'(1);
            res_nxt       = ST_TIMEOUT;
          end else begin
            wait_wd.valid = 1'b1;
            res_nxt       = ST_WAIT;
          end
        end else if (!w_free_ok_r) begin
          res_nxt = ST_FULL;
        end else begin
          wait_we       = 1'b1;
          wait_wa       = w_free_r;
          wait_wd.valid = 1'b1;
          wait_wd.xid   = xid_r;
          wait_wd.key   = key_r;
          wait_wd.mode  = mode_r;
          wait_wd.age   = 16'd0;
          wait_cnt_nxt  = wait_cnt_r + WCW'(1);
          res_nxt       = ST_WAIT;
        end
      end
      OP_DONE: begin
        strobe_nxt   = 1'b1;
        o_status_nxt = res_r;
        o_holds_nxt  = (act_r == ACT_QUERY) && h_found_r;
        o_mheld_nxt  = (act_r == ACT_QUERY) && k_found_r &&
                       ((mode_r == MODE_SHARED) ? (k_sc_r != '0) : k_excl_r);
        o_rel_nxt    = (act_r != ACT_RELEASE) ? 7'd0 :
                       ((32'(rel_cnt_r) > 32'd127) ? 7'd127 : 7'(rel_cnt_r));
        o_held_nxt   = (32'(held_cnt_r) > 32'd127) ? 7'd127 : 7'(held_cnt_r);
        o_wait_nxt   = (32'(wait_cnt_r) > 32'd63) ? 6'd63 : 6'(wait_cnt_r);
      end
      default: begin
      end
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (cmd.op == OP_KRD) key_rd_r <= key_mem[kidx_r];
  end

  always_ff @(posedge clk) begin
    if (held_we) held_mem[held_wa] <= held_wd;
    if (cmd.op == OP_HRD) held_rd_r <= held_mem[hidx_r];
  end

  always_ff @(posedge clk) begin
    if (wait_we) wait_mem[wait_wa] <= wait_wd;
    if (cmd.op == OP_WRD) wait_rd_r <= wait_mem[widx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= 16'd0;
      held_cnt_r <= '0;
      wait_cnt_r <= '0;
      strobe_r   <= 1'b0;
      cidx_r     <= '0;
      hidx_r     <= '0;
      kidx_r     <= '0;
      widx_r     <= '0;
      h_found_r  <= 1'b0;  h_free_ok_r <= 1'b0;
      k_found_r  <= 1'b0;  k_free_ok_r <= 1'b0;
      w_found_r  <= 1'b0;  w_free_ok_r <= 1'b0;
    end else begin
      if (cfg_valid) limit_r <= cfg_data;
      held_cnt_r <= held_cnt_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      strobe_r   <= strobe_nxt;
      cidx_r     <= cidx_nxt;
      hidx_r     <= hidx_nxt;
      kidx_r     <= kidx_nxt;
      widx_r     <= widx_nxt;
      h_found_r  <= h_found_nxt;  h_free_ok_r <= h_free_ok_nxt;
      k_found_r  <= k_found_nxt;  k_free_ok_r <= k_free_ok_nxt;
      w_found_r  <= w_found_nxt;  w_free_ok_r <= w_free_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;    xid_r     <= xid_nxt;   key_r    <= key_nxt;
    mode_r     <= mode_nxt;   h_mode_r  <= h_mode_nxt; h_free_r <= h_free_nxt;
    k_idx_r    <= k_idx_nxt;  k_free_r  <= k_free_nxt; k_sc_r  <= k_sc_nxt;
    k_excl_r   <= k_excl_nxt; k_exid_r  <= k_exid_nxt;
    w_idx_r    <= w_idx_nxt;  w_free_r  <= w_free_nxt; w_age_r <= w_age_nxt;
    rl_key_r   <= rl_key_nxt; rl_mode_r <= rl_mode_nxt;
    rel_cnt_r  <= rel_cnt_nxt; res_r    <= res_nxt;
    o_status_r <= o_status_nxt; o_holds_r <= o_holds_nxt; o_mheld_r <= o_mheld_nxt;
    o_rel_r    <= o_rel_nxt;  o_held_r  <= o_held_nxt; o_wait_r <= o_wait_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_status         = o_status_r;
  assign out_holds_lock     = o_holds_r;
  assign out_mode_is_held   = o_mheld_r;
  assign out_released_count = o_rel_r;
  assign out_held_total     = o_held_r;
  assign out_waiting_total  = o_wait_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_cnt_r) <= HELD_ENTRIES)
    else $error("held count beyond table size");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wait_cnt_r) <= WAIT_ENTRIES)
    else $error("waiting count beyond table size");

  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held for two cycles");

endmodule

`default_nettype wire
